// ===== rtl/dlps_pkg.sv =====
// Shared constants, types and helpers of the delay-line pitch shifter.
// No dependencies; used by dlps_store, delay_line_pitch_shifter_top, dlps_checker and the testbench.
package dlps_pkg;

  localparam int DELAY_DEPTH = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = ADDR_W + FRAC_BITS;
  localparam int WSHIFT      = 15 - (ADDR_W - 1);
  localparam int GAIN_W      = 16;
  localparam int STEP_W      = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd3;

  localparam logic signed [STEP_W-1:0] PITCH_STEP_RST    = 20'sd65536;
  localparam logic [GAIN_W-1:0]        WET_GAIN_RST      = 16'd32768;
  localparam logic [GAIN_W-1:0]        DRY_GAIN_RST      = 16'd0;
  localparam logic signed [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'sd4096;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    sample_t           wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] wr_index;
    logic              wrapped;
    sample_t           fwd;
  } store_req_t;

  function automatic sample_t sat_sample(input logic signed [63:0] v);
    sample_t r;
    if (v > SAMPLE_MAX) begin
      r = sample_t'(SAMPLE_MAX);
    end else if (v < SAMPLE_MIN) begin
      r = sample_t'(SAMPLE_MIN);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/dlps_store.sv =====
// Circular sample store: one write port, one registered read port.
// Masks entries not yet written since reset and forwards the current input sample.
// Depends on dlps_pkg.
module dlps_store (
  input  logic                 clk_i,
  input  dlps_pkg::store_req_t req_i,
  output dlps_pkg::sample_t    rd_data_o
);

  dlps_pkg::sample_t         mem_q [dlps_pkg::DELAY_DEPTH];
  dlps_pkg::sample_t         rdata_q;
  logic [dlps_pkg::ADDR_W-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  always_comb begin
    if (raddr_q == req_i.wr_index) begin
      rd_data_o = req_i.fwd;
    end else if (!req_i.wrapped && (raddr_q > req_i.wr_index)) begin
      rd_data_o = '0;
    end else begin
      rd_data_o = rdata_q;
    end
  end

endmodule

// ===== rtl/delay_line_pitch_shifter_top.sv =====
// Delay-line pitch shifter, top level: stream ports, register file, sequencer, datapath.
// Depends on dlps_pkg and dlps_store.
// Sequencing: an accepted request passes through ST_A, ST_B, ST_W, ST_Y and ST_F; no new request is taken
// until the item retires, as the two tap reads share the single store read port and the four multiplies run in turn.
// The result waits in an output register; a stalled output holds the last step.
// Reset is asynchronous, active low; stored samples read as zero until first written.
module delay_line_pitch_shifter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dlps_pkg::TDATA_W-1:0]        s_axis_tdata,  // [15:0] sample_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dlps_pkg::TDATA_W-1:0]        m_axis_tdata,  // [15:0] sample_out
  input  logic                                cfg_we_i,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dlps_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int SB      = dlps_pkg::SAMPLE_BITS;
  localparam int AW      = dlps_pkg::ADDR_W;
  localparam int PW      = dlps_pkg::POS_W;
  localparam int GW      = dlps_pkg::GAIN_W;
  localparam int PROD_W  = SB + 19;
  localparam int BLEND_W = SB + 16;
  localparam int DRY_W   = SB + GW + 1;
  localparam int ACC_W   = BLEND_W + GW + 2;
  localparam int FB_W    = GW + SB + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A,
    ST_B,
    ST_W,
    ST_Y,
    ST_F
  } state_e;

  state_e                         state_q;
  logic                           out_valid_q;
  dlps_pkg::sample_t              out_data_q;

  logic signed [dlps_pkg::STEP_W-1:0] pitch_step_q;
  logic [GW-1:0]                  wet_gain_q;
  logic [GW-1:0]                  dry_gain_q;
  logic signed [GW-1:0]           feedback_gain_q;

  logic [AW-1:0]                  wr_index_q;
  logic                           wrapped_q;
  logic [PW-1:0]                  read_pos_q;
  logic [PW-1:0]                  read_pos_d;

  dlps_pkg::sample_t              x_q;
  dlps_pkg::sample_t              a_q;
  logic [GW:0]                    weight_q;
  logic signed [DRY_W-1:0]        dry_q;
  logic signed [BLEND_W-1:0]      blend_q;
  logic signed [ACC_W-1:0]        acc_q;
  dlps_pkg::sample_t              y_q;

  logic                           accept;
  logic                           out_free;
  logic                           retire;
  logic [AW-1:0]                  tap_a;
  logic [AW-1:0]                  tap_b;
  logic [AW-1:0]                  wdist;
  logic [AW-1:0]                  tap_dist;
  dlps_pkg::sample_t              rd_data;
  logic signed [SB:0]             diff;
  logic signed [PROD_W-1:0]       prod;
  logic signed [BLEND_W-1:0]      blend_d;
  logic signed [ACC_W-1:0]        acc_d;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [FB_W-1:0]         fb_prod;
  logic signed [FB_W-1:0]         fb;
  logic signed [FB_W:0]           store_sum;
  dlps_pkg::store_req_t           st_req;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign retire        = (state_q == ST_F) && out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dlps_pkg::TDATA_W'($unsigned(out_data_q));

  assign tap_a = read_pos_q[PW-1:dlps_pkg::FRAC_BITS];
  assign tap_b = {~tap_a[AW-1], tap_a[AW-2:0]};
  assign wdist = wr_index_q - tap_a;
  assign tap_dist = wdist[AW-1] ? (~wdist + AW'(1)) : wdist;

  assign diff    = (SB+1)'(a_q) - (SB+1)'(rd_data);
  assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, weight_q}));
  assign blend_d = BLEND_W'((PROD_W'(rd_data) <<< 15) + prod);
  assign acc_d   = ACC_W'(blend_q) * ACC_W'($signed({1'b0, wet_gain_q}))
                 + (ACC_W'(dry_q) <<< 15);
  assign rnd     = (acc_q + (ACC_W'(1) <<< 29)) >>> 30;
  assign fb_prod = FB_W'(feedback_gain_q) * FB_W'(y_q) + FB_W'(16384);
  assign fb      = fb_prod >>> 15;
  assign store_sum = (FB_W+1)'(x_q) + (FB_W+1)'(fb);

  assign read_pos_d = read_pos_q + PW'(1 << dlps_pkg::FRAC_BITS) + PW'(pitch_step_q);

  always_comb begin
    st_req          = '0;
    st_req.we       = retire;
    st_req.waddr    = wr_index_q;
    st_req.wdata    = dlps_pkg::sat_sample(64'(store_sum));
    st_req.raddr    = (state_q == ST_A) ? tap_b : tap_a;
    st_req.wr_index = wr_index_q;
    st_req.wrapped  = wrapped_q;
    st_req.fwd      = x_q;
  end

  dlps_store u_store (
    .clk_i     (clk_i),
    .req_i     (st_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_step_q    <= dlps_pkg::PITCH_STEP_RST;
      wet_gain_q      <= dlps_pkg::WET_GAIN_RST;
      dry_gain_q      <= dlps_pkg::DRY_GAIN_RST;
      feedback_gain_q <= dlps_pkg::FEEDBACK_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dlps_pkg::CFG_PITCH_STEP:    pitch_step_q    <= cfg_data_i[dlps_pkg::STEP_W-1:0];
        dlps_pkg::CFG_WET_GAIN:      wet_gain_q      <= cfg_data_i[GW-1:0];
        dlps_pkg::CFG_DRY_GAIN:      dry_gain_q      <= cfg_data_i[GW-1:0];
        dlps_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      wr_index_q  <= '0;
      wrapped_q   <= 1'b0;
      read_pos_q  <= '0;
    end else begin
      if (m_axis_tready && !retire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_A;
          end
        end
        ST_A: state_q <= ST_B;
        ST_B: state_q <= ST_W;
        ST_W: state_q <= ST_Y;
        ST_Y: state_q <= ST_F;
        ST_F: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_data_q  <= y_q;
            wr_index_q  <= wr_index_q + AW'(1);
            wrapped_q   <= wrapped_q || (&wr_index_q);
            read_pos_q  <= read_pos_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= s_axis_tdata[SB-1:0];
    end
    if (state_q == ST_A) begin
      a_q      <= rd_data;
      weight_q <= (GW+1)'(tap_dist) << dlps_pkg::WSHIFT;
      dry_q    <= DRY_W'(x_q) * DRY_W'($signed({1'b0, dry_gain_q}));
    end
    if (state_q == ST_B) begin
      blend_q <= blend_d;
    end
    if (state_q == ST_W) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_Y) begin
      y_q <= dlps_pkg::sat_sample(64'(rnd));
    end
  end

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("new request taken while an item is in progress");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_F))
    else $error("result shown without a finished item");

  a_write_retires : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.we |=> (m_axis_tvalid && s_axis_tready))
    else $error("store write without result delivery and return to idle");

endmodule

// ===== verif/dlps_checker.sv =====
// Checker for the delay-line pitch shifter: watches the request, result and register ports,
// predicts each output sample and compares it with the block's result stream.
// Depends on dlps_pkg.
`timescale 1ns / 100ps

module dlps_checker
  import dlps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TDATA_W-1:0]   in_data_i,    // [15:0] sample_in
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TDATA_W-1:0]   out_data_i,   // [15:0] sample_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   err_count_o,
  output int                   pending_o
);

  localparam longint Q15_ONE     = 64'sd32768;
  localparam longint POS_WRAP    = longint'(DELAY_DEPTH) <<< FRAC_BITS;
  localparam longint HALF_SPAN   = longint'(DELAY_DEPTH / 2) <<< FRAC_BITS;

  sample_t     line_mem [DELAY_DEPTH];
  int unsigned head;
  longint      tap_pos;
  longint      step_q16;
  longint      wet_q15;
  longint      dry_q15;
  longint      fb_q15;
  sample_t     out_expected [$];
  sample_t     want;
  sample_t     got;
  int          n_err;

  function automatic sample_t clamp_sample(input longint v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  // Advance the shifter by one input sample and return the mixed output.
  function automatic sample_t shift_sample(input sample_t x);
    longint      pos_b;
    longint      weight;
    longint      blend;
    longint      acc;
    longint      y;
    longint      fb;
    int unsigned tap_a;
    int unsigned tap_b;
    int unsigned tap_dist;
    pos_b = tap_pos + HALF_SPAN;
    if (pos_b >= POS_WRAP) pos_b -= POS_WRAP;
    line_mem[head] = x;
    tap_a = int'(tap_pos >>> FRAC_BITS) % DELAY_DEPTH;
    tap_b = int'(pos_b >>> FRAC_BITS) % DELAY_DEPTH;
    tap_dist = (head > tap_a) ? head - tap_a : tap_a - head;
    if (DELAY_DEPTH - tap_dist < tap_dist) tap_dist = DELAY_DEPTH - tap_dist;
    weight = longint'(tap_dist) * Q15_ONE / longint'(DELAY_DEPTH / 2);
    if (weight > Q15_ONE) weight = Q15_ONE;
    blend = weight * longint'(line_mem[tap_a])
          + (Q15_ONE - weight) * longint'(line_mem[tap_b]);
    acc = blend * wet_q15 + longint'(x) * dry_q15 * Q15_ONE;
    y   = longint'(clamp_sample((acc + (64'sd1 <<< 29)) >>> 30));
    fb  = (fb_q15 * y + 64'sd16384) >>> 15;
    line_mem[head] = clamp_sample(longint'(x) + fb);
    head = (head == DELAY_DEPTH - 1) ? 0 : head + 1;
    tap_pos += (64'sd1 <<< FRAC_BITS) + step_q16;
    if (tap_pos >= POS_WRAP) tap_pos -= POS_WRAP;
    if (tap_pos < 0) tap_pos += POS_WRAP;
    return sample_t'(y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DELAY_DEPTH; i++) line_mem[i] = '0;
      head     = 0;
      tap_pos  = 0;
      step_q16 = 64'sd65536;
      wet_q15  = 64'sd32768;
      dry_q15  = 64'sd0;
      fb_q15   = 64'sd4096;
      out_expected.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PITCH_STEP:    step_q16 = longint'($signed(cfg_data_i[STEP_W-1:0]));
          CFG_WET_GAIN:      wet_q15  = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_DRY_GAIN:      dry_q15  = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_FEEDBACK_GAIN: fb_q15   = longint'($signed(cfg_data_i[GAIN_W-1:0]));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = sample_t'(out_data_i[SAMPLE_BITS-1:0]);
        if (out_expected.size() == 0) begin
          n_err++;
          $display("%0t: sample_out expected none, got %0d", $time, got);
        end else begin
          want = out_expected.pop_front();
          if (got !== want) begin
            n_err++;
            $display("%0t: sample_out expected %0d, got %0d", $time, want, got);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        out_expected.push_back(shift_sample(sample_t'(in_data_i[SAMPLE_BITS-1:0])));
      pending_o <= out_expected.size();
    end
    err_count_o <= n_err;
  end

endmodule

// ===== verif/tb_delay_line_pitch_shifter_top.sv =====
// Testbench top for delay_line_pitch_shifter_top: clock, reset, sample requests, register
// settings and random output back-pressure; dlps_checker predicts and compares.
// Depends on dlps_pkg, dlps_checker and the block's RTL.
`timescale 1ns / 100ps

module tb_delay_line_pitch_shifter_top;
  import dlps_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 113;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 12;
  localparam int HOLD_PHASE  = 3;
  localparam int STEADY_PHASE = 5;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_PITCH_STEP;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  logic hold_go = 1'b0;
  logic steady  = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  always #2 clk_i = ~clk_i;

  delay_line_pitch_shifter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dlps_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input sample_t v);
    while (!steady && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= TDATA_W'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop the request, wait for every result, then let the block go quiet.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic signed [STEP_W-1:0] step,
                            input logic [GAIN_W-1:0] wet,
                            input logic [GAIN_W-1:0] dry,
                            input logic signed [GAIN_W-1:0] fb);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PITCH_STEP;
    cfg_data_i  <= step;
    @(posedge clk_i);
    cfg_index_i <= CFG_WET_GAIN;
    cfg_data_i  <= {4'($urandom), wet};
    @(posedge clk_i);
    cfg_index_i <= CFG_DRY_GAIN;
    cfg_data_i  <= {4'($urandom), dry};
    @(posedge clk_i);
    cfg_index_i <= CFG_FEEDBACK_GAIN;
    cfg_data_i  <= {4'($urandom), fb};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic sample_t pick_sample;
    int unsigned mode;
    mode = $urandom_range(9);
    case (mode)
      0:       return sample_t'({$urandom_range(1), {15{$urandom_range(1) == 1}}});
      1, 2:    return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic phase_setting(input int p);
    case (p)
      0: write_regs(-20'sd524288, 16'hFFFF, 16'hFFFF, -16'sd32768);
      1: write_regs(20'sd524287, 16'd0, 16'd32768, 16'sd32767);
      2: write_regs(-20'sd65536, 16'd32768, 16'd0, 16'sd0);
      3: write_regs(20'sd262144, 16'd32768, 16'd16384, -16'sd16384);
      4: write_regs(-20'sd262144, 16'd0, 16'd0, 16'sd32767);
      default: write_regs(STEP_W'(int'($urandom_range(524288)) - 262144),
                          GAIN_W'($urandom_range(40000)), GAIN_W'($urandom_range(40000)),
                          GAIN_W'($urandom));
    endcase
  endtask

  // Receiver: random back-pressure, one long hold-off when asked.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 37);
    end
  end

  initial begin
    sample_t first_run [14];
    sample_t hot_run [10];
    first_run = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555,
                  16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000,
                  16'sd100, -16'sd100};
    hot_run   = '{16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001, 16'sh0000, 16'sd20000,
                  -16'sd20000, 16'sh7FFF, -16'sh8000, 16'sh7FFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (first_run[i]) send_sample(first_run[i]);
    drain();
    write_regs(-20'sd65536, 16'hFFFF, 16'hFFFF, -16'sd32768);
    foreach (hot_run[i]) send_sample(hot_run[i]);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      phase_setting(p);
      hold_go <= (p == HOLD_PHASE);
      steady  <= (p == HOLD_PHASE) || (p == STEADY_PHASE);
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end
    steady <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
